// ===== hdl/rlee_pkg.sv =====
// Shared types and constants for the run-length escape stream encoder.
`timescale 1ns / 1ps

package rlee_pkg;

    // Longest run held before it is released: a match past this count starts a new run
    localparam logic [4:0] RUN_LIMIT = 5'd31;

    // Most bytes a single input transaction can produce
    localparam int MAX_BYTES = 5;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int IDX_W     = $clog2(MAX_BYTES);

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Input item kinds
    typedef enum logic [1:0] {
        OP_DATA  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_CTRL  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    // Configuration register indexes
    localparam logic [1:0] REG_ENCODE_ENABLE = 2'd0;
    localparam logic [1:0] REG_ESCAPE_BYTE   = 2'd1;
    localparam logic [1:0] REG_IN_DATA_CODE  = 2'd2;

    typedef struct packed {
        logic       encode_enable;
        logic [7:0] escape_byte;
        logic [7:0] in_data_code;
    } cfg_t;

    // Byte sequence produced by one input transaction
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [CNT_W-1:0]          cnt;
    } desc_t;

    // Front to queue write side
    typedef struct packed {
        logic  push;
        desc_t desc;
    } qwr_t;

    // Queue read side to back
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } qrd_t;

endpackage

// ===== hdl/rlee_front.sv =====
// Front end: accepts input items, tracks the pending run, builds byte sequences.
`timescale 1ns / 1ps

module rlee_front
    import rlee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] in_op,
    input  logic [7:0] in_byte,
    input  logic       q_full,
    output qwr_t       qwr
);

    logic       pend_valid_reg, pend_valid_next;
    logic [7:0] pend_byte_reg, pend_byte_next;
    logic [4:0] extra_reg, extra_next;

    logic                      accept;
    op_t                       op;
    logic                      do_release;
    logic [CNT_W-1:0]          rel_n;
    logic [MAX_BYTES-1:0][7:0] rel;
    logic [1:0]                tail_n;
    logic [7:0]                tail0, tail1;
    logic [CNT_W-1:0]          total;
    logic [MAX_BYTES-1:0][7:0] seq;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign op       = op_t'(in_op);

    // Classify the item and work out release and tail bytes
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        extra_next      = extra_reg;
        do_release      = 1'b0;
        tail_n          = 2'd0;
        tail0           = cfg.escape_byte;
        tail1           = in_byte;
        if (!cfg.encode_enable)
        begin
            // pass-through; a held run stays untouched
            if (op == OP_DATA || op == OP_CTRL)
            begin
                tail_n = 2'd1;
                tail0  = in_byte;
            end
        end
        else
        begin
            unique case (op)
                OP_DATA:
                begin
                    if (pend_valid_reg && in_byte == pend_byte_reg && extra_reg < RUN_LIMIT)
                    begin
                        extra_next = extra_reg + 5'd1;
                    end
                    else
                    begin
                        do_release = 1'b1;
                        if (in_byte == cfg.escape_byte)
                        begin
                            tail_n          = 2'd2;
                            tail1           = cfg.in_data_code;
                            pend_valid_next = 1'b0;
                            pend_byte_next  = 8'd0;
                            extra_next      = 5'd0;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_byte_next  = in_byte;
                            extra_next      = 5'd0;
                        end
                    end
                end
                OP_FLUSH:
                begin
                    do_release      = 1'b1;
                    pend_valid_next = 1'b0;
                    pend_byte_next  = 8'd0;
                    extra_next      = 5'd0;
                end
                OP_CTRL:
                begin
                    do_release      = 1'b1;
                    tail_n          = 2'd2;
                    pend_valid_next = 1'b0;
                    pend_byte_next  = 8'd0;
                    extra_next      = 5'd0;
                end
                OP_NONE:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    // Bytes that release the pending run
    always_comb
    begin
        rel   = '0;
        rel_n = '0;
        if (do_release && pend_valid_reg)
        begin
            if (extra_reg == 5'd0)
            begin
                rel_n  = CNT_W'(1);
                rel[0] = pend_byte_reg;
            end
            else if (extra_reg == 5'd1)
            begin
                rel_n  = CNT_W'(2);
                rel[0] = pend_byte_reg;
                rel[1] = pend_byte_reg;
            end
            else
            begin
                rel_n  = CNT_W'(3);
                rel[0] = cfg.escape_byte;
                rel[1] = {3'b000, extra_reg};
                rel[2] = pend_byte_reg;
            end
        end
    end

    // Merge release bytes and tail bytes into one sequence
    always_comb
    begin
        total = rel_n + CNT_W'(tail_n);
        seq   = '0;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (CNT_W'(i) < rel_n)
                seq[i] = rel[i];
            else if (CNT_W'(i) == rel_n)
                seq[i] = tail0;
            else if (CNT_W'(i) == rel_n + CNT_W'(1))
                seq[i] = tail1;
        end
    end

    assign qwr.push       = accept && (total != '0);
    assign qwr.desc.bytes = seq;
    assign qwr.desc.cnt   = total;

    // Pending run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= 8'd0;
            extra_reg      <= 5'd0;
        end
        else if (accept)
        begin
            pend_valid_reg <= pend_valid_next;
            pend_byte_reg  <= pend_byte_next;
            extra_reg      <= extra_next;
        end
    end

endmodule

// ===== hdl/rlee_queue.sv =====
// Short FIFO of byte sequences between front and back.
`timescale 1ns / 1ps

module rlee_queue
    import rlee_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  qwr_t qwr,
    output logic full,
    output qrd_t qrd,
    input  logic pop
);

    desc_t          mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]   count_reg;
    logic           do_push, do_pop;

    assign full      = (count_reg == (QAW+1)'(QDEPTH));
    assign qrd.valid = (count_reg != '0);
    assign qrd.desc  = mem_reg[rd_ptr_reg];
    assign do_push   = qwr.push && !full;
    assign do_pop    = pop && qrd.valid;

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= qwr.desc;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QAW'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + (QAW+1)'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - (QAW+1)'(1);
        end
    end

endmodule

// ===== hdl/rlee_back.sv =====
// Back end: serializes queued byte sequences onto the output stream.
`timescale 1ns / 1ps

module rlee_back
    import rlee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  qrd_t       qrd,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last
);

    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             valid_reg, valid_next;
    logic [7:0]       byte_reg;
    logic             last_reg;
    logic             load;
    logic             is_last;

    assign load    = qrd.valid && (!valid_reg || out_ready);
    assign is_last = (CNT_W'(idx_reg) == qrd.desc.cnt - CNT_W'(1));
    assign pop     = load && is_last;

    // Next byte index and output valid
    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_last ? '0 : idx_reg + IDX_W'(1);
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= qrd.desc.bytes[idx_reg];
            last_reg <= is_last;
        end
    end

    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;
    assign out_last  = last_reg;

endmodule

// ===== hdl/rle_escape_stream_encoder_unit.sv =====
// Top level of the run-length escape stream encoder.
`timescale 1ns / 1ps

// Accepts one input transaction per cycle while the four-entry sequence queue
// has room; each input yields zero to five output bytes, and the back end
// drives one output byte per cycle while the receiver is ready, so throughput
// is bounded by the output side. Configuration writes take effect at the
// next clock edge and are meant to be done while the block is idle.
module rle_escape_stream_encoder_unit
    import rlee_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write port
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0] s_axis_tuser,   // [1:0] op
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast
);

    cfg_t cfg_reg;
    qwr_t qwr;
    qrd_t qrd;
    logic q_full;
    logic q_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ENCODE_ENABLE: cfg_reg.encode_enable <= cfg_data[0];
                REG_ESCAPE_BYTE:   cfg_reg.escape_byte   <= cfg_data;
                REG_IN_DATA_CODE:  cfg_reg.in_data_code  <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    rlee_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser),
        .in_byte  (s_axis_tdata),
        .q_full   (q_full),
        .qwr      (qwr)
    );

    rlee_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .qwr   (qwr),
        .full  (q_full),
        .qrd   (qrd),
        .pop   (q_pop)
    );

    rlee_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .qrd       (qrd),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the run-length escape stream encoder.
`timescale 1ns / 1ps

module tb_top;
    import rlee_pkg::*;

    localparam int QUIET_LIMIT = 2000;   // cycles with no transaction before giving up
    localparam int SETTLE      = 12;     // cycles allowed after the last expected byte

    // One expected output byte
    typedef struct packed {
        logic [7:0] val;
        logic       last;
    } coded_byte_t;

    // Encoder predictor plus the queue of bytes it still expects to see
    class rle_coder_check;
        bit          enc_on;
        logic [7:0]  esc;
        logic [7:0]  data_code;
        bit          held;
        logic [7:0]  held_byte;
        logic [4:0]  repeats;
        coded_byte_t coded_q[$];
        int          errors;
        int          compared;

        function new();
            enc_on    = 1'b0;
            esc       = 8'h00;
            data_code = 8'h00;
            held      = 1'b0;
            held_byte = 8'h00;
            repeats   = 5'd0;
            errors    = 0;
            compared  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [7:0] v);
            case (idx)
                REG_ENCODE_ENABLE: enc_on    = v[0];
                REG_ESCAPE_BYTE:   esc       = v;
                REG_IN_DATA_CODE:  data_code = v;
                default: ;
            endcase
        endfunction

        // Emit the held run, if any, and clear it
        function void release_run(ref logic [7:0] seq[$]);
            if (!held)
                return;
            if (repeats == 5'd0)
            begin
                seq.push_back(held_byte);
            end
            else if (repeats == 5'd1)
            begin
                seq.push_back(held_byte);
                seq.push_back(held_byte);
            end
            else
            begin
                seq.push_back(esc);
                seq.push_back({3'b000, repeats});
                seq.push_back(held_byte);
            end
            held      = 1'b0;
            held_byte = 8'h00;
            repeats   = 5'd0;
        endfunction

        // Accepted input transaction: work out the bytes it causes
        function void take_item(op_t op, logic [7:0] b);
            logic [7:0] seq[$];
            if (op == OP_NONE)
                return;
            if (!enc_on)
            begin
                if (op != OP_FLUSH)
                    seq.push_back(b);
            end
            else
            begin
                case (op)
                    OP_DATA:
                    begin
                        if (held && b == held_byte && repeats < RUN_LIMIT)
                        begin
                            repeats = repeats + 5'd1;
                        end
                        else
                        begin
                            release_run(seq);
                            if (b == esc)
                            begin
                                seq.push_back(esc);
                                seq.push_back(data_code);
                            end
                            else
                            begin
                                held      = 1'b1;
                                held_byte = b;
                                repeats   = 5'd0;
                            end
                        end
                    end
                    OP_FLUSH: release_run(seq);
                    default:
                    begin
                        release_run(seq);
                        seq.push_back(esc);
                        seq.push_back(b);
                    end
                endcase
            end
            foreach (seq[i])
                coded_q.push_back('{val: seq[i], last: (i == seq.size() - 1)});
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= 10)
                $display("[%0t] MISMATCH: %s", $realtime, msg);
        endfunction

        // Accepted output transaction: compare with the oldest expected byte
        function void compare_byte(logic [7:0] b, logic last);
            coded_byte_t e;
            compared++;
            if (coded_q.size() == 0)
            begin
                flag($sformatf("unexpected byte %02h last %0b", b, last));
                return;
            end
            e = coded_q.pop_front();
            if (e.val !== b)
                flag($sformatf("byte: expected %02h, got %02h", e.val, b));
            if (e.last !== last)
                flag($sformatf("last on byte %02h: expected %0b, got %0b", e.val, e.last, last));
        endfunction

        function int outstanding();
            return coded_q.size();
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    rle_coder_check sb;
    int sender_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int quiet_cycles;
    int items_sent;
    int settings_used;

    rle_escape_stream_encoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    always #4 clk = ~clk;

    // Receiver: long hold-off when requested, else random stalls
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // Monitor: feed the predictor, check outputs, watch for a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.take_item(op_t'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.compare_byte(m_axis_tdata, m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Timeout: no transaction for %0d cycles, %0d bytes still expected",
                         QUIET_LIMIT, sb.outstanding());
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // Offer one input transaction, with a random gap first
    task automatic send_item(op_t op, logic [7:0] b);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < sender_idle_pct)
            gap++;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (op != OP_NONE)
            items_sent++;
    endtask

    // Stop offering and wait until every expected byte is out
    task automatic drain();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] v);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        sb.set_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(bit en, logic [7:0] e, logic [7:0] code);
        write_reg(REG_ENCODE_ENABLE, {7'd0, en});
        write_reg(REG_ESCAPE_BYTE, e);
        write_reg(REG_IN_DATA_CODE, code);
        settings_used++;
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1:       begin sender_idle_pct = 55; recv_stall_pct = 0;  end
            2:       begin sender_idle_pct = 0;  recv_stall_pct = 55; end
            3:       begin sender_idle_pct = 9;  recv_stall_pct = 9;  end
            default: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // Mostly runs of one byte with random content, plus noise items
    task automatic random_phase(int n_items);
        int start;
        int len;
        int r;
        logic [7:0] b;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            r = $urandom_range(0, 99);
            if (r < 75)
            begin
                b = ($urandom_range(0, 5) == 0) ? sb.esc : 8'($urandom_range(0, 255));
                len = ($urandom_range(0, 11) == 0) ? $urandom_range(28, 36)
                                                   : $urandom_range(1, 5);
                repeat (len) send_item(OP_DATA, b);
                r = $urandom_range(0, 9);
                if (r < 2)
                    send_item(OP_FLUSH, 8'($urandom_range(0, 255)));
                else if (r < 4)
                    send_item(OP_CTRL, 8'($urandom_range(0, 255)));
            end
            else
            begin
                send_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // Main sequence
    initial
    begin
        int p;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = REG_ENCODE_ENABLE;
        cfg_data        = 8'h00;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = 8'h00;
        s_axis_tuser    = OP_DATA;
        m_axis_tready   = 1'b0;
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        hold_left       = 0;
        quiet_cycles    = 0;
        items_sent      = 0;
        settings_used   = 1;
        sb = new();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: everything passes through, flush gives nothing
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'hFF);
        send_item(OP_CTRL, 8'hA5);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_NONE, 8'hFF);
        drain();

        // Encoding on: single, pair, long run, control, escape in data
        set_config(1'b1, 8'hA5, 8'h5A);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_DATA, 8'h00);
        send_item(OP_DATA, 8'h01);
        send_item(OP_DATA, 8'h01);
        send_item(OP_DATA, 8'hFF);
        repeat (3) send_item(OP_DATA, 8'hFF);
        send_item(OP_CTRL, 8'h80);
        send_item(OP_DATA, 8'hA5);
        send_item(OP_DATA, 8'h33);
        send_item(OP_DATA, 8'h33);
        send_item(OP_NONE, 8'h33);
        drain();

        // Held run survives a stretch with encoding off
        write_reg(REG_ENCODE_ENABLE, 8'h00);
        send_item(OP_DATA, 8'h44);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_CTRL, 8'h00);
        drain();
        write_reg(REG_ENCODE_ENABLE, 8'h01);
        send_item(OP_DATA, 8'h33);
        send_item(OP_FLUSH, 8'h00);

        // Escape changed while a run is held: match wins over escape test
        send_item(OP_DATA, 8'h20);
        drain();
        write_reg(REG_ESCAPE_BYTE, 8'h20);
        send_item(OP_DATA, 8'h20);
        send_item(OP_FLUSH, 8'h00);
        send_item(OP_DATA, 8'h20);
        drain();

        // Receiver held off while distinct bytes keep coming: the queue fills
        hold_left = 60;
        for (int i = 0; i < 16; i++)
            send_item(OP_DATA, 8'h40 + 8'(i));
        send_item(OP_FLUSH, 8'h00);
        drain();

        // Random phases over several settings and idling patterns
        for (p = 0; p < 8; p++)
        begin
            case (p)
                0:       set_config(1'b1, 8'h00, 8'hFF);
                1:       set_config(1'b1, 8'hFF, 8'h00);
                3:       set_config(1'b0, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
                default: set_config($urandom_range(0, 3) != 0, 8'($urandom_range(0, 255)),
                                    8'($urandom_range(0, 255)));
            endcase
            set_idling(p % 4);
            // Long receiver hold-off so the input side backs up
            if (p == 0)
                hold_left = 150;
            random_phase(10);
            drain();
        end

        if (sb.outstanding() != 0)
            sb.flag($sformatf("%0d expected bytes never arrived", sb.outstanding()));
        $display("Covered %0d input transactions over %0d register settings: pass-through,",
                 items_sent, settings_used);
        $display("runs up to saturation, escapes in data, flush and control; %0d bytes checked.",
                 sb.compared);
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
